// ----- hdl/trfhe_pkg.sv -----
// Shared types, byte codes and the connect negotiation table for the telnet receive filter.
package trfhe_pkg;

   localparam logic [7:0] B_IAC      = 8'd255;
   localparam logic [7:0] B_DONT     = 8'd254;
   localparam logic [7:0] B_DO       = 8'd253;
   localparam logic [7:0] B_WONT     = 8'd252;
   localparam logic [7:0] B_WILL     = 8'd251;
   localparam logic [7:0] B_SB       = 8'd250;
   localparam logic [7:0] B_SE       = 8'd240;
   localparam logic [7:0] OPT_ECHO   = 8'd1;
   localparam logic [7:0] OPT_SGA    = 8'd3;
   localparam logic [7:0] OPT_LINEMODE = 8'd34;
   localparam logic [7:0] B_CTRLC    = 8'h03;
   localparam logic [7:0] B_ESC      = 8'h1B;
   localparam logic [7:0] B_PLUS     = 8'h2B;
   localparam logic [7:0] B_PRINT_LO = 8'd32;
   localparam logic [7:0] B_PRINT_HI = 8'd126;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int NEG_LEN = 12;
   localparam int IDX_W   = $clog2(NEG_LEN);

   typedef enum logic [1:0] {
      REQ_BYTE    = 2'd0,
      REQ_CONNECT = 2'd1,
      REQ_HOST    = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      KIND_HOST  = 3'd0,
      KIND_REPLY = 3'd1,
      KIND_CMD   = 3'd2,
      KIND_CTRLC = 3'd3,
      KIND_PLUS  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_DATA    = 3'd0,
      PH_IAC     = 3'd1,
      PH_OPTION  = 3'd2,
      PH_SUB     = 3'd3,
      PH_SUB_IAC = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      JOB_SINGLE = 2'd0,
      JOB_REPLY  = 2'd1,
      JOB_FLUSH  = 2'd2,
      JOB_NEGOT  = 2'd3
   } job_op_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0] out_kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_item_type;

   // One unit of work handed from the classifier to the emitter.
   typedef struct packed {
      job_op_type op;
      kind_type   kind;
      logic [7:0] data;
      logic [7:0] verb;
      logic [1:0] plus_cnt;
      logic       has_data;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // IAC WILL SGA, IAC DO SGA, IAC WILL ECHO, IAC DONT LINEMODE
   function automatic logic [7:0] neg_byte(input logic [IDX_W-1:0] idx);
      logic [7:0] b;
      unique case (idx)
         4'd0, 4'd3, 4'd6, 4'd9: b = B_IAC;
         4'd1, 4'd7:             b = B_WILL;
         4'd4:                   b = B_DO;
         4'd10:                  b = B_DONT;
         4'd2, 4'd5:             b = OPT_SGA;
         4'd8:                   b = OPT_ECHO;
         4'd11:                  b = OPT_LINEMODE;
         default:                b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

// ----- hdl/trfhe_front.sv -----
// Front end: telnet phase tracking, host escape detection and job classification.
module trfhe_front import trfhe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_item_type req_item,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   output logic         job_valid,
   output job_type      job
);

   phase_type  phase_ff, phase_in;
   logic [7:0] pending_ff, pending_in;
   logic       host_ff, host_in;
   logic       primed_ff, primed_in;
   logic [1:0] esc_ff, esc_in;
   logic       auto_ff;

   logic [7:0] b;
   logic       is_data;
   logic       printable;

   assign b         = req_item.rx_byte;
   assign printable = (b == B_ESC) || (b >= B_PRINT_LO && b <= B_PRINT_HI);

   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_ff;
      host_in    = host_ff;
      primed_in  = primed_ff;
      esc_in     = esc_ff;
      job_valid  = 1'b0;
      job        = '0;
      is_data    = 1'b0;

      case (req_item.req_type)
         REQ_BYTE: begin
            unique case (phase_ff)
               PH_DATA: begin
                  if (b == B_IAC) phase_in = PH_IAC;
                  else is_data = 1'b1;
               end
               PH_IAC: begin
                  if (b == B_DO || b == B_DONT || b == B_WILL || b == B_WONT) begin
                     pending_in = b;
                     phase_in   = PH_OPTION;
                  end else if (b == B_SB) begin
                     phase_in = PH_SUB;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
               PH_OPTION: begin
                  job.op   = JOB_REPLY;
                  job.kind = KIND_REPLY;
                  job.data = b;
                  if (pending_ff == B_DO) begin
                     job_valid = 1'b1;
                     job.verb  = (b == OPT_SGA || b == OPT_ECHO) ? B_WILL : B_WONT;
                  end else if (pending_ff == B_WILL) begin
                     job_valid = 1'b1;
                     job.verb  = (b == OPT_SGA) ? B_DO : B_DONT;
                  end
                  phase_in = PH_DATA;
               end
               PH_SUB: begin
                  if (b == B_IAC) phase_in = PH_SUB_IAC;
               end
               PH_SUB_IAC: begin
                  phase_in = (b == B_SE) ? PH_DATA : PH_SUB;
               end
               default: begin
                  phase_in = PH_DATA;
                  is_data  = 1'b1;
               end
            endcase

            if (is_data) begin
               if (!host_ff) begin
                  job_valid = 1'b1;
                  job.op    = JOB_SINGLE;
                  job.kind  = KIND_CMD;
                  job.data  = b;
               end else if (b == B_CTRLC) begin
                  host_in   = 1'b0;
                  primed_in = 1'b0;
                  esc_in    = 2'd0;
                  job_valid = 1'b1;
                  job.op    = JOB_SINGLE;
                  job.kind  = KIND_CTRLC;
               end else if (b == B_PLUS) begin
                  if (esc_ff == 2'd2) begin
                     host_in   = 1'b0;
                     primed_in = 1'b0;
                     esc_in    = 2'd0;
                     job_valid = 1'b1;
                     job.op    = JOB_SINGLE;
                     job.kind  = KIND_PLUS;
                  end else begin
                     esc_in = esc_ff + 2'd1;
                  end
               end else begin
                  // broken '+' run is flushed first, then the byte if the path is primed or the byte is printable
                  esc_in = 2'd0;
                  if (printable) primed_in = 1'b1;
                  job.op       = (esc_ff != 2'd0) ? JOB_FLUSH : JOB_SINGLE;
                  job.kind     = KIND_HOST;
                  job.data     = b;
                  job.plus_cnt = esc_ff;
                  job.has_data = primed_ff || printable;
                  job_valid    = (esc_ff != 2'd0) || primed_ff || printable;
               end
            end
         end
         REQ_CONNECT: begin
            phase_in   = PH_DATA;
            pending_in = 8'd0;
            primed_in  = 1'b0;
            esc_in     = 2'd0;
            host_in    = auto_ff;
            if (!auto_ff) begin
               job_valid = 1'b1;
               job.op    = JOB_NEGOT;
               job.kind  = KIND_REPLY;
            end
         end
         REQ_HOST: begin
            host_in   = 1'b1;
            primed_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DATA;
         pending_ff <= 8'd0;
         host_ff    <= 1'b0;
         primed_ff  <= 1'b0;
         esc_ff     <= 2'd0;
         auto_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) auto_ff <= csr_wr_data;
         if (accept) begin
            phase_ff   <= phase_in;
            pending_ff <= pending_in;
            host_ff    <= host_in;
            primed_ff  <= primed_in;
            esc_ff     <= esc_in;
         end
      end
   end

endmodule

// ----- hdl/trfhe_job_queue.sv -----
// Small job queue between the classifier and the emitter.
module trfhe_job_queue import trfhe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  job_type          wr_job,
   input  logic             rd_en,
   output job_type          rd_job,
   output queue_status_type status
);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wptr_ff, rptr_ff;
   logic [QCNT_W-1:0]  count_ff;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign rd_job       = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wptr_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (wr_en) wptr_ff <= wptr_ff + QPTR_W'(1);
         if (rd_en) rptr_ff <= rptr_ff + QPTR_W'(1);
         if (wr_en && !rd_en) count_ff <= count_ff + QCNT_W'(1);
         else if (rd_en && !wr_en) count_ff <= count_ff - QCNT_W'(1);
      end
   end

endmodule

// ----- hdl/trfhe_back.sv -----
// Back end: expands one job into its result bytes into the response register.
module trfhe_back import trfhe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         job_avail,
   input  job_type      job,
   output logic         job_done,
   input  logic         pop,
   output logic         empty,
   output rsp_item_type rsp_item
);

   logic              rsp_valid_ff;
   rsp_item_type      rsp_ff, rsp_in;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  len;
   logic              advance;

   assign advance  = job_avail && (!rsp_valid_ff || pop);
   assign job_done = advance && rsp_in.last;
   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_ff;

   always_comb begin
      rsp_in          = '0;
      rsp_in.out_kind = job.kind;
      len             = IDX_W'(1);
      unique case (job.op)
         JOB_SINGLE: begin
            len             = IDX_W'(1);
            rsp_in.out_byte = job.data;
         end
         JOB_REPLY: begin
            len = IDX_W'(3);
            if (idx_ff == IDX_W'(0))      rsp_in.out_byte = B_IAC;
            else if (idx_ff == IDX_W'(1)) rsp_in.out_byte = job.verb;
            else                          rsp_in.out_byte = job.data;
         end
         JOB_FLUSH: begin
            len = IDX_W'(job.plus_cnt) + IDX_W'(job.has_data);
            rsp_in.out_byte = (idx_ff < IDX_W'(job.plus_cnt)) ? B_PLUS : job.data;
         end
         JOB_NEGOT: begin
            len             = IDX_W'(NEG_LEN);
            rsp_in.out_byte = neg_byte(idx_ff);
         end
         default: ;
      endcase
      rsp_in.last = (idx_ff == len - IDX_W'(1));
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= rsp_in.last ? '0 : idx_ff + IDX_W'(1);
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- hdl/telnet_rx_filter_host_escape.sv -----
// Top level of the telnet receive filter with host escape detection.
//
//   channel   ports                          handshake
//   request   req_item, push, full           accepted when push && !full
//   response  rsp_item, empty, pop           accepted when pop && !empty
//   csr       csr_wr_en, csr_wr_data         written when csr_wr_en
//
// One request is taken per cycle unless full; its job goes via the job queue into the
// response register. While pop keeps up, a job gives one response per cycle: 1 for most
// bytes, 3 for an option reply, up to 3 for a '+' flush, 12 for the connect negotiation.
// The four-entry job queue absorbs reply bursts; full rises only when it fills.
// Synchronous active-high reset clears all telnet and host state and host_auto_start.
module telnet_rx_filter_host_escape import trfhe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   logic             accept;
   logic             job_valid;
   job_type          new_job;
   job_type          head_job;
   logic             job_done;
   queue_status_type q_status;

   assign full   = q_status.full;
   assign accept = push && !q_status.full;

   trfhe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .job_valid   (job_valid),
      .job         (new_job)
   );

   trfhe_job_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (accept && job_valid),
      .wr_job (new_job),
      .rd_en  (job_done),
      .rd_job (head_job),
      .status (q_status)
   );

   trfhe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_avail (!q_status.empty),
      .job       (head_job),
      .job_done  (job_done),
      .pop       (pop),
      .empty     (empty),
      .rsp_item  (rsp_item)
   );

   a_reset_clears: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("request or response side not idle after reset");

   a_exit_single: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_item.out_kind == KIND_CTRLC || rsp_item.out_kind == KIND_PLUS))
      |-> (rsp_item.out_byte == 8'd0 && rsp_item.last))
      else $error("host exit request not a lone zero byte");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.out_kind <= KIND_PLUS))
      else $error("response kind out of range");

   a_job_drain: assert property (@(posedge clock) disable iff (reset)
      job_done |-> !q_status.empty)
      else $error("job retired from an empty queue");

endmodule

// ----- dv/tb_telnet_rx_filter_host_escape.sv -----
// Testbench for the telnet receive filter: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module tb_telnet_rx_filter_host_escape;
   import trfhe_pkg::*;

   localparam int          CYCLE_LIMIT = 300000;
   localparam int          DRAIN_WAIT  = 8;
   localparam logic [7:0]  B_NOP       = 8'd241;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push;
   logic         full;
   req_item_type req_item;
   logic         empty;
   logic         pop;
   rsp_item_type rsp_item;
   logic         csr_wr_en;
   logic         csr_wr_data;

   // predictor state
   phase_type    tn_phase;
   logic [7:0]   tn_verb;
   logic         host_on;
   logic         host_primed;
   logic [1:0]   plus_held;
   logic         auto_start;

   rsp_item_type burst_rsp[$];
   rsp_item_type expected_rsp[$];

   int           failures = 0;
   int           tx_count = 0;
   int           cycle_count = 0;
   bit           tx_no_idle = 0;
   bit           rx_no_idle = 0;
   int           rx_long_hold = 0;

   telnet_rx_filter_host_escape u_top (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_item    (req_item),
      .empty       (empty),
      .pop         (pop),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic void emit_rsp(input kind_type kind, input logic [7:0] b);
      rsp_item_type r;
      r.out_kind = kind;
      r.out_byte = b;
      r.last     = 1'b0;
      burst_rsp.push_back(r);
   endfunction

   function automatic void emit_reply(input logic [7:0] verb, input logic [7:0] opt);
      emit_rsp(KIND_REPLY, B_IAC);
      emit_rsp(KIND_REPLY, verb);
      emit_rsp(KIND_REPLY, opt);
   endfunction

   function automatic void clear_filter_state();
      tn_phase    = PH_DATA;
      tn_verb     = 8'd0;
      host_on     = 1'b0;
      host_primed = 1'b0;
      plus_held   = 2'd0;
   endfunction

   function automatic void leave_host();
      host_on     = 1'b0;
      host_primed = 1'b0;
      plus_held   = 2'd0;
   endfunction

   // Returns 1 when the byte belongs to a telnet command sequence.
   function automatic bit telnet_consume(input logic [7:0] b);
      bit used;
      used = 1'b1;
      case (tn_phase)
         PH_DATA: begin
            if (b == B_IAC) tn_phase = PH_IAC;
            else used = 1'b0;
         end
         PH_IAC: begin
            if (b == B_DO || b == B_DONT || b == B_WILL || b == B_WONT) begin
               tn_verb  = b;
               tn_phase = PH_OPTION;
            end else if (b == B_SB) begin
               tn_phase = PH_SUB;
            end else begin
               tn_phase = PH_DATA;
            end
         end
         PH_OPTION: begin
            if (tn_verb == B_DO)
               emit_reply((b == OPT_SGA || b == OPT_ECHO) ? B_WILL : B_WONT, b);
            else if (tn_verb == B_WILL)
               emit_reply((b == OPT_SGA) ? B_DO : B_DONT, b);
            tn_phase = PH_DATA;
         end
         PH_SUB: begin
            if (b == B_IAC) tn_phase = PH_SUB_IAC;
         end
         PH_SUB_IAC: begin
            if (b == B_SE) tn_phase = PH_DATA;
            else tn_phase = PH_SUB;
         end
         default: begin
            tn_phase = PH_DATA;
            used     = 1'b0;
         end
      endcase
      return used;
   endfunction

   function automatic void route_data(input logic [7:0] b);
      int i;
      if (!host_on) begin
         emit_rsp(KIND_CMD, b);
         return;
      end
      if (b == B_CTRLC) begin
         leave_host();
         emit_rsp(KIND_CTRLC, 8'd0);
         return;
      end
      if (plus_held != 2'd0) begin
         if (b == B_PLUS) begin
            plus_held = plus_held + 2'd1;
            if (plus_held == 2'd3) begin
               leave_host();
               emit_rsp(KIND_PLUS, 8'd0);
            end
            return;
         end
         // broken escape run goes to the host, primed or not
         for (i = 0; i < plus_held; i++) emit_rsp(KIND_HOST, B_PLUS);
         plus_held = 2'd0;
      end
      if (b == B_PLUS) begin
         plus_held = 2'd1;
         return;
      end
      if (!host_primed) begin
         if (b == B_ESC || (b >= B_PRINT_LO && b <= B_PRINT_HI)) host_primed = 1'b1;
         else return;
      end
      emit_rsp(KIND_HOST, b);
   endfunction

   function automatic void predict_filter(input req_item_type it);
      case (it.req_type)
         REQ_BYTE: begin
            if (!telnet_consume(it.rx_byte)) route_data(it.rx_byte);
         end
         REQ_CONNECT: begin
            clear_filter_state();
            if (auto_start) begin
               host_on = 1'b1;
            end else begin
               emit_reply(B_WILL, OPT_SGA);
               emit_reply(B_DO, OPT_SGA);
               emit_reply(B_WILL, OPT_ECHO);
               emit_reply(B_DONT, OPT_LINEMODE);
            end
         end
         REQ_HOST: begin
            host_on     = 1'b1;
            host_primed = 1'b0;
         end
         default: ;
      endcase
      if (burst_rsp.size() > 0) burst_rsp[burst_rsp.size() - 1].last = 1'b1;
      foreach (burst_rsp[i]) expected_rsp.push_back(burst_rsp[i]);
      burst_rsp.delete();
   endfunction

   task automatic send_req(input req_code_type code, input logic [7:0] b);
      req_item_type it;
      int unsigned  gap;
      it.req_type = code;
      it.rx_byte  = b;
      gap = tx_no_idle ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push     <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_filter(it);
      if (code != REQ_UNUSED) tx_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_req(REQ_BYTE, b);
   endtask

   task automatic send_ctrl(input req_code_type code);
      send_req(code, 8'($urandom_range(0, 255)));
   endtask

   // Stop offering and let every expected response come out.
   task automatic wait_drain();
      @(negedge clock);
      push <= 1'b0;
      while (expected_rsp.size() > 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_auto_start(input logic value);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      auto_start  = value;
   endtask

   task automatic test_command_path();
      send_byte(8'h00);
      send_byte(B_DONT);
      send_byte(8'h7F);
   endtask

   task automatic test_telnet_negotiation();
      send_ctrl(REQ_CONNECT);
      send_byte(B_IAC); send_byte(B_DO); send_byte(OPT_ECHO);
      send_byte(B_IAC); send_byte(B_WILL); send_byte(8'hFF);
      // doubled IAC is swallowed
      send_byte(B_IAC); send_byte(B_IAC);
      send_byte(B_IAC); send_byte(B_SB); send_byte(B_IAC); send_byte(8'h20);
      send_byte(B_IAC); send_byte(B_SE);
   endtask

   task automatic test_host_escape();
      send_ctrl(REQ_HOST);
      send_byte(8'h01);
      send_byte(B_PLUS);
      send_byte(8'h02);
      send_byte(B_ESC);
      send_byte(B_PLUS); send_byte(B_PLUS); send_byte(B_CTRLC);
      send_ctrl(REQ_HOST);
      send_byte(B_PLUS); send_byte(B_PLUS); send_byte(B_PLUS);
   endtask

   task automatic test_auto_start();
      write_auto_start(1'b1);
      send_ctrl(REQ_CONNECT);
      send_byte(B_PRINT_HI);
      send_ctrl(REQ_UNUSED);
      write_auto_start(1'b0);
   endtask

   task automatic test_backpressure();
      rx_long_hold = 80;
      tx_no_idle   = 1;
      send_ctrl(REQ_CONNECT);
      repeat (10) send_byte(8'($urandom_range(B_PRINT_LO, B_PRINT_HI)));
      tx_no_idle = 0;
      wait_drain();
   endtask

   task automatic random_option();
      logic [7:0] verb;
      logic [7:0] opt;
      case ($urandom_range(0, 3))
         0: verb = B_DO;
         1: verb = B_DONT;
         2: verb = B_WILL;
         default: verb = B_WONT;
      endcase
      case ($urandom_range(0, 3))
         0: opt = OPT_ECHO;
         1: opt = OPT_SGA;
         2: opt = OPT_LINEMODE;
         default: opt = 8'($urandom_range(0, 255));
      endcase
      send_byte(B_IAC); send_byte(verb); send_byte(opt);
   endtask

   task automatic random_subneg();
      int unsigned n;
      n = $urandom_range(0, 4);
      send_byte(B_IAC); send_byte(B_SB);
      repeat (n) send_byte(8'($urandom_range(0, 254)));
      send_byte(B_IAC);
      // mostly a proper end, sometimes a stray byte that keeps us inside
      if ($urandom_range(0, 3) != 0) send_byte(B_SE);
      else send_byte(8'($urandom_range(0, 239)));
   endtask

   task automatic test_random_traffic(input int n_items);
      int          start;
      int unsigned pick;
      int unsigned n;
      start = tx_count;
      while (tx_count - start < n_items) begin
         if ($urandom_range(0, 15) == 0) begin
            tx_no_idle = ($urandom_range(0, 2) == 0);
            rx_no_idle = ($urandom_range(0, 2) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) send_ctrl(REQ_CONNECT);
         else if (pick < 9) send_ctrl(REQ_HOST);
         else if (pick < 11) send_ctrl(REQ_UNUSED);
         else if (pick < 25) random_option();
         else if (pick < 30) random_subneg();
         else if (pick < 34) begin
            send_byte(B_IAC);
            send_byte($urandom_range(0, 1) ? B_NOP : 8'($urandom_range(0, 255)));
         end else if (pick < 48) begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(B_PLUS);
            if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 254)));
         end else if (pick < 53) send_byte(B_CTRLC);
         else if (pick < 57) send_byte(B_ESC);
         else if (pick < 80) send_byte(8'($urandom_range(B_PRINT_LO, B_PRINT_HI)));
         else send_byte(8'($urandom_range(0, 255)));
      end
      tx_no_idle = 0;
      rx_no_idle = 0;
   endtask

   function automatic void check_rsp(input rsp_item_type got);
      rsp_item_type want;
      if (expected_rsp.size() == 0) begin
         $display("%0t: response with none expected: kind %0d byte %02h last %0b",
                  $time, got.out_kind, got.out_byte, got.last);
         failures++;
         return;
      end
      want = expected_rsp.pop_front();
      if (got.out_kind !== want.out_kind) begin
         $display("%0t: out_kind mismatch: expected %0d actual %0d",
                  $time, want.out_kind, got.out_kind);
         failures++;
      end
      if (got.out_byte !== want.out_byte) begin
         $display("%0t: out_byte mismatch: expected %02h actual %02h",
                  $time, want.out_byte, got.out_byte);
         failures++;
      end
      if (got.last !== want.last) begin
         $display("%0t: last mismatch: expected %0b actual %0b",
                  $time, want.last, got.last);
         failures++;
      end
   endfunction

   // response side
   initial begin
      int unsigned stall;
      pop = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (rx_long_hold > 0) begin
            stall        = rx_long_hold;
            rx_long_hold = 0;
         end else if (rx_no_idle) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 6);
         end
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         check_rsp(rsp_item);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      push        = 1'b0;
      req_item    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      auto_start  = 1'b0;
      clear_filter_state();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_command_path();
      test_telnet_negotiation();
      test_host_escape();
      test_auto_start();
      test_backpressure();
      test_random_traffic(25);
      write_auto_start(1'b1);
      test_random_traffic(20);
      write_auto_start(1'b0);
      test_random_traffic(20);

      wait_drain();
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
